// ===== design/debounced_toggle_and_blink_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the debounced toggle and blink controller
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_TOGGLE_AND_BLINK_CONTROLLER_TOP_ASSERT_SVH
`define DEBOUNCED_TOGGLE_AND_BLINK_CONTROLLER_TOP_ASSERT_SVH

// Overlapping implication, ignored while reset is high.
`define DTBC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtbc check failed");

// Next-cycle implication, ignored while reset is high.
`define DTBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtbc check failed");

// Next-cycle implication that is also checked across reset.
`define DTBC_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dtbc reset check failed");

`endif

// ===== design/dtbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtbc_pkg
// Types and constants shared by the debounced toggle and blink controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtbc_pkg;

   localparam int IN_BITS   = 40;   // 35 field bits padded to whole bytes
   localparam int OUT_BITS  = 200;  // 195 field bits padded to whole bytes
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 16;

   localparam logic [15:0] RST_DEBOUNCE  = 16'd50;
   localparam logic [15:0] RST_OFF_DUR   = 16'd500;
   localparam logic [15:0] RST_BASE_UNIT = 16'd100;
   localparam logic [7:0]  RST_MIN_UNITS = 8'd1;
   localparam logic [7:0]  RST_MAX_UNITS = 8'd10;
   localparam logic [7:0]  RST_INIT_UNITS = 8'd5;
   localparam logic [23:0] RST_TARGET    = 24'(RST_INIT_UNITS * RST_BASE_UNIT);

   typedef enum logic [CSR_AW-1:0] {
      CSR_DEBOUNCE  = 3'd0,
      CSR_OFF_DUR   = 3'd1,
      CSR_BASE_UNIT = 3'd2,
      CSR_MIN_UNITS = 3'd3,
      CSR_MAX_UNITS = 3'd4,
      CSR_INIT_UNITS = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] off_duration_ms;
      logic [15:0] base_unit_ms;
      logic [7:0]  min_units;
      logic [7:0]  max_units;
   } cfg_type;

   typedef struct packed {
      logic        main_led;
      logic        blink_led;
      logic        blink_hold;
      logic [7:0]  units_now;
      logic [23:0] on_target_ms;
      logic [31:0] toggles;
      logic [31:0] cycles;
      logic [31:0] incs;
      logic [31:0] decs;
      logic [31:0] on_accum_ms;
   } result_type;

endpackage

// ===== design/dtbc_core.sv =====
// ----------------------------------------------------------------------------
// dtbc_core
// Controller state and the combinational update for one tick word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtbc_core
   import dtbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [31:0] now_ms,
   input  logic        toggle_level,
   input  logic        inc_level,
   input  logic        dec_level,
   input  cfg_type     cfg,
   output result_type  result
);

   logic [2:0]  prev_ff, prev_in;
   logic [31:0] edge_ff [3];
   logic [31:0] edge_in [3];
   logic        main_ff, main_in;
   logic        blink_ff, blink_in;
   logic [31:0] trans_ff, trans_in;
   logic [31:0] sample_ff, sample_in;
   logic [31:0] accum_ff, accum_in;
   logic [7:0]  units_ff, units_in;
   logic [23:0] target_ff, target_in;
   logic [31:0] tog_cnt_ff, tog_cnt_in;
   logic [31:0] cyc_cnt_ff, cyc_cnt_in;
   logic [31:0] inc_cnt_ff, inc_cnt_in;
   logic [31:0] dec_cnt_ff, dec_cnt_in;

   logic [2:0]  levels;
   logic [2:0]  hit;
   logic [31:0] elapsed;
   logic [7:0]  units_mid;

   assign levels = {dec_level, inc_level, toggle_level};

   // A press counts on a rising edge spaced at least the debounce time from
   // that button's last accepted edge, with wrapping time differences.
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         hit[b] = levels[b] && !prev_ff[b] &&
                  ((now_ms - edge_ff[b]) >= {16'd0, cfg.debounce_ms});
      end
   end

   assign elapsed = now_ms - trans_ff;
   assign units_mid = (hit[1] && (units_ff < cfg.max_units)) ? units_ff + 8'd1 : units_ff;

   always_comb begin
      prev_in    = prev_ff;
      edge_in    = edge_ff;
      main_in    = main_ff;
      blink_in   = blink_ff;
      trans_in   = trans_ff;
      sample_in  = sample_ff;
      accum_in   = accum_ff;
      units_in   = units_ff;
      target_in  = target_ff;
      tog_cnt_in = tog_cnt_ff;
      cyc_cnt_in = cyc_cnt_ff;
      inc_cnt_in = inc_cnt_ff;
      dec_cnt_in = dec_cnt_ff;
      if (step) begin
         prev_in = levels;
         for (int b = 0; b < 3; b++) begin
            if (hit[b]) begin
               edge_in[b] = now_ms;
            end
         end

         // Toggle task.
         if (hit[0]) begin
            main_in    = !main_ff;
            tog_cnt_in = tog_cnt_ff + 32'd1;
         end

         // Blink task; turning the main LED on forces the blink LED off.
         if (main_in) begin
            blink_in  = 1'b0;
            trans_in  = now_ms;
            sample_in = now_ms;
         end else begin
            sample_in = now_ms;
            if (blink_ff) begin
               accum_in = accum_ff + (now_ms - sample_ff);
               if (elapsed >= {8'd0, target_ff}) begin
                  blink_in = 1'b0;
                  trans_in = now_ms;
               end
            end else if (elapsed >= {16'd0, cfg.off_duration_ms}) begin
               blink_in   = 1'b1;
               trans_in   = now_ms;
               cyc_cnt_in = cyc_cnt_ff + 32'd1;
            end
         end

         // Adjust task: increase first, then decrease on the updated count.
         if (hit[1] && (units_ff < cfg.max_units)) begin
            inc_cnt_in = inc_cnt_ff + 32'd1;
         end
         units_in = units_mid;
         if (hit[2] && (units_mid > cfg.min_units)) begin
            units_in   = units_mid - 8'd1;
            dec_cnt_in = dec_cnt_ff + 32'd1;
         end
         if (hit[1] || hit[2]) begin
            target_in = {16'd0, units_in} * {8'd0, cfg.base_unit_ms};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         edge_ff    <= '{default: '0};
         main_ff    <= 1'b0;
         blink_ff   <= 1'b0;
         trans_ff   <= '0;
         sample_ff  <= '0;
         accum_ff   <= '0;
         units_ff   <= RST_INIT_UNITS;
         target_ff  <= RST_TARGET;
         tog_cnt_ff <= '0;
         cyc_cnt_ff <= '0;
         inc_cnt_ff <= '0;
         dec_cnt_ff <= '0;
      end else begin
         prev_ff    <= prev_in;
         edge_ff    <= edge_in;
         main_ff    <= main_in;
         blink_ff   <= blink_in;
         trans_ff   <= trans_in;
         sample_ff  <= sample_in;
         accum_ff   <= accum_in;
         units_ff   <= units_in;
         target_ff  <= target_in;
         tog_cnt_ff <= tog_cnt_in;
         cyc_cnt_ff <= cyc_cnt_in;
         inc_cnt_ff <= inc_cnt_in;
         dec_cnt_ff <= dec_cnt_in;
      end
   end

   always_comb begin
      result.main_led     = main_in;
      result.blink_led    = blink_in;
      result.blink_hold   = main_in;
      result.units_now    = units_in;
      result.on_target_ms = target_in;
      result.toggles      = tog_cnt_in;
      result.cycles       = cyc_cnt_in;
      result.incs         = inc_cnt_in;
      result.decs         = dec_cnt_in;
      result.on_accum_ms  = accum_in;
   end

endmodule

// ===== design/debounced_toggle_and_blink_controller_top.sv =====
// ----------------------------------------------------------------------------
// debounced_toggle_and_blink_controller_top
// Debounced toggle, blink timer and window adjust, one result per tick word.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  req_     | in        | tick word: time and three button levels
//  rsp_     | out       | LED states, units, target, counters, on-time sum
//  csr_     | in        | register writes, no read-back
//
//  A word is taken into an input register, then updated against the state and
//  written to the result register; one word per cycle is sustained while
//  rsp_tready stays high. The result register stalls on rsp_tready low;
//  the input register then still takes one more word. Synchronous reset
//  restores register defaults and state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_toggle_and_blink_controller_top
   import dtbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [IN_BITS-1:0]  req_tdata,  // now_ms, toggle_level, inc_level, dec_level
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OUT_BITS-1:0] rsp_tdata,  // main_led, blink_led, blink_hold, units_now,
                                           // on_target_ms, toggles, cycles, incs, decs,
                                           // on_accum_ms
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   cfg_type     cfg_ff;
   logic        in_valid_ff;
   logic [31:0] in_now_ff;
   logic [2:0]  in_lvl_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  result;
   logic        advance;
   logic        step;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // The initial unit count only matters at reset, where it always holds its
   // default, so a write to it has nothing to change.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= RST_DEBOUNCE;
         cfg_ff.off_duration_ms <= RST_OFF_DUR;
         cfg_ff.base_unit_ms    <= RST_BASE_UNIT;
         cfg_ff.min_units       <= RST_MIN_UNITS;
         cfg_ff.max_units       <= RST_MAX_UNITS;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms     <= csr_wdata;
            CSR_OFF_DUR:    cfg_ff.off_duration_ms <= csr_wdata;
            CSR_BASE_UNIT:  cfg_ff.base_unit_ms    <= csr_wdata;
            CSR_MIN_UNITS:  cfg_ff.min_units       <= csr_wdata[7:0];
            CSR_MAX_UNITS:  cfg_ff.max_units       <= csr_wdata[7:0];
            CSR_INIT_UNITS: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_now_ff <= req_tdata[31:0];
         in_lvl_ff <= req_tdata[34:32];
      end
      if (step) begin
         out_ff <= result;
      end
   end

   dtbc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .now_ms       (in_now_ff),
      .toggle_level (in_lvl_ff[0]),
      .inc_level    (in_lvl_ff[1]),
      .dec_level    (in_lvl_ff[2]),
      .cfg          (cfg_ff),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0,
                        out_ff.on_accum_ms,
                        out_ff.decs,
                        out_ff.incs,
                        out_ff.cycles,
                        out_ff.toggles,
                        out_ff.on_target_ms,
                        out_ff.units_now,
                        out_ff.blink_hold,
                        out_ff.blink_led,
                        out_ff.main_led};

endmodule

// ===== design/dtbc_checker.sv =====
// ----------------------------------------------------------------------------
// dtbc_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "debounced_toggle_and_blink_controller_top_assert.svh"

module dtbc_checker
   import dtbc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [OUT_BITS-1:0] rsp_tdata
);

   // Nothing comes out in the cycle after reset.
   `DTBC_ASSERT_RST(a_idle_after_reset, clock, reset, !rsp_tvalid)

   // A stalled result word holds.
   `DTBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // The hold flag mirrors the main LED, and the blink LED is dark while it is on.
   `DTBC_ASSERT_IMPL(a_hold_led, clock, reset, rsp_tvalid,
      (rsp_tdata[2] == rsp_tdata[0]) && !(rsp_tdata[0] && rsp_tdata[1]))

   // With the result side empty, the input side never stalls.
   `DTBC_ASSERT_IMPL(a_no_stall, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind debounced_toggle_and_blink_controller_top dtbc_checker u_dtbc_checker (.*);
